/* hw/rtl/itrt_pkg.sv */
package itrt_pkg;

  localparam int ValW      = 64;
  localparam int DecDigits = 20;
  localparam int BcdW      = 4 * DecDigits;
  localparam int IdxW      = 6;

  // mode codes carried on in_func
  localparam logic [2:0] FN_SDEC = 3'd0;
  localparam logic [2:0] FN_UDEC = 3'd1;
  localparam logic [2:0] FN_BIN  = 3'd2;
  localparam logic [2:0] FN_OCT  = 3'd3;
  localparam logic [2:0] FN_HEX  = 3'd4;

  // top digit index for each mode
  localparam logic [IdxW-1:0] TopDec = 6'd19;
  localparam logic [IdxW-1:0] TopHex = 6'd15;
  localparam logic [IdxW-1:0] TopOct = 6'd21;
  localparam logic [IdxW-1:0] TopBin = 6'd63;

  localparam logic [7:0] CharMinus = 8'h2d;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharAlpha = 8'h57;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIGN,
    ST_DIGITS
  } itrt_state_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d);
    logic [7:0] r;
    if (d < 4'd10) begin
      r = CharZero + {4'b0000, d};
    end else begin
      r = CharAlpha + {4'b0000, d};
    end
    return r;
  endfunction

endpackage

/* hw/rtl/itrt_bcd.sv */
module itrt_bcd
  import itrt_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [ValW-1:0] mag,
  output logic            done,
  output logic [BcdW-1:0] bcd
);

  logic            busy_r;
  logic [5:0]      cnt_r;
  logic            done_r;
  logic [ValW-1:0] sh_r;
  logic [BcdW-1:0] bcd_r;
  logic [BcdW-1:0] adj;

  // add 3 to every bcd digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < DecDigits; i++) begin
      if (bcd_r[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd_r[4*i +: 4] + 4'd3;
      end else begin
        adj[4*i +: 4] = bcd_r[4*i +: 4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && (cnt_r == '0);
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'(ValW - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh_r  <= mag;
      bcd_r <= '0;
    end else if (busy_r) begin
      sh_r  <= {sh_r[ValW-2:0], 1'b0};
      bcd_r <= {adj[BcdW-2:0], sh_r[ValW-1]};
    end
  end

  assign done = done_r;
  assign bcd  = bcd_r;

endmodule

/* hw/rtl/integer_to_radix_text.sv */
// channel  ports                                         direction
// in       in_valid in_ready in_value in_func in_zero_pad  request in
// out      out_valid out_ready out_character out_last      one character out
//
// one digit position per cycle from the top digit while the output is not stalled;
// leading zeros are skipped, also while the output is stalled.
// decimal modes wait on the shift-and-add-3 converter, then walk 20 digit positions,
// after a minus sign if negative. unused modes are accepted and give no characters.
// a single output register holds the pending character; a stall there holds
// the digit walk. reset is synchronous and returns the sequencer to idle.
module integer_to_radix_text
  import itrt_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [ValW-1:0] in_value,
  input  logic [2:0]      in_func,
  input  logic            in_zero_pad,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      out_character,
  output logic            out_last
);

  itrt_state_t     state_r, state_nxt;
  logic [2:0]      func_r, func_nxt;
  logic            skip_r, skip_nxt;
  logic            neg_r, neg_nxt;
  logic [IdxW-1:0] idx_r, idx_nxt;
  logic [ValW-1:0] val_r, val_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [7:0]      out_char_r, out_char_nxt;
  logic            out_last_r, out_last_nxt;

  logic            conv_start;
  logic            conv_done;
  logic [BcdW-1:0] bcd;
  logic            accept;
  logic            out_free;
  logic            in_neg;
  logic            pad_eff;
  logic [3:0]      dig;
  logic [ValW+1:0] oct_ext;
  logic [6:0]      oct_base;
  logic            lead_zero;

  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign in_neg   = (in_func == FN_SDEC) && in_value[ValW-1];
  assign pad_eff  = in_zero_pad &&
                    (in_func == FN_UDEC || in_func == FN_BIN || in_func == FN_HEX);
  assign conv_start = accept && (in_func == FN_SDEC || in_func == FN_UDEC);

  itrt_bcd u_bcd (
    .clk  (clk),
    .rst_n(rst_n),
    .start(conv_start),
    .mag  (val_nxt),
    .done (conv_done),
    .bcd  (bcd)
  );

  // digit at the current position, per mode
  assign oct_ext  = {2'b00, val_r};
  assign oct_base = 7'(idx_r[4:0]) * 7'd3;
  always_comb begin
    case (func_r) inside
      FN_SDEC, FN_UDEC: dig = bcd[{idx_r[4:0], 2'b00} +: 4];
      FN_HEX:           dig = val_r[{idx_r[3:0], 2'b00} +: 4];
      FN_OCT:           dig = {1'b0, oct_ext[oct_base +: 3]};
      default:          dig = {3'b000, val_r[idx_r]};
    endcase
  end

  assign lead_zero = skip_r && (dig == 4'd0) && (idx_r != '0);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_func == FN_SDEC || in_func == FN_UDEC) begin
            state_nxt = ST_CONV;
          end else if (in_func == FN_BIN || in_func == FN_OCT || in_func == FN_HEX) begin
            state_nxt = ST_DIGITS;
          end
        end
      end
      ST_CONV: begin
        if (conv_done) begin
          state_nxt = neg_r ? ST_SIGN : ST_DIGITS;
        end
      end
      ST_SIGN: begin
        if (out_free) begin
          state_nxt = ST_DIGITS;
        end
      end
      ST_DIGITS: begin
        if (!lead_zero && out_free && idx_r == '0) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    in_ready      = (state_r == ST_IDLE);
    func_nxt      = func_r;
    skip_nxt      = skip_r;
    neg_nxt       = neg_r;
    idx_nxt       = idx_r;
    val_nxt       = val_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          func_nxt = in_func;
          skip_nxt = !pad_eff;
          neg_nxt  = in_neg;
          val_nxt  = in_neg ? (ValW'(0) - in_value) : in_value;
          case (in_func)
            FN_HEX:  idx_nxt = TopHex;
            FN_OCT:  idx_nxt = TopOct;
            FN_BIN:  idx_nxt = TopBin;
            default: idx_nxt = TopDec;
          endcase
        end
      end
      ST_CONV: begin
      end
      ST_SIGN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = CharMinus;
          out_last_nxt  = 1'b0;
        end
      end
      ST_DIGITS: begin
        if (lead_zero) begin
          idx_nxt = idx_r - 6'd1;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = digit_char(dig);
          out_last_nxt  = (idx_r == '0);
          skip_nxt      = 1'b0;
          if (idx_r != '0) begin
            idx_nxt = idx_r - 6'd1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r     <= func_nxt;
    skip_r     <= skip_nxt;
    neg_r      <= neg_nxt;
    idx_r      <= idx_nxt;
    val_r      <= val_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_character = out_char_r;
  assign out_last      = out_last_r;

endmodule

/* verif/radix_text_checker.sv */
module radix_text_checker
  import itrt_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_ready,
  input  logic [ValW-1:0] in_value,
  input  logic [2:0]      in_func,
  input  logic            in_zero_pad,
  input  logic            out_valid,
  input  logic            out_ready,
  input  logic [7:0]      out_character,
  input  logic            out_last,
  output int              fail_count,
  output int              pending_count,
  output int              chars_checked
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [127:0] DigitSet   = "0123456789abcdef";
  localparam logic [7:0]   AsciiZero  = "0";
  localparam logic [7:0]   AsciiMinus = "-";
  localparam int           PadDecW    = 20;
  localparam int           PadHexW    = 16;
  localparam int           PadBinW    = 64;
  localparam int           MaxReports = 40;

  typedef struct packed {
    logic [7:0] character;
    logic       is_last;
  } text_char_t;

  text_char_t expected_text[$];
  int         mismatches = 0;
  int         checked = 0;

  // expected characters of one request, most significant first
  function automatic void append_radix_text(input logic [ValW-1:0] value,
                                            input logic [2:0] func,
                                            input logic pad);
    logic [ValW-1:0] mag;
    logic [ValW-1:0] rem;
    logic [7:0]      digs [0:63];
    logic [3:0]      d;
    logic            neg;
    int              n;
    int              width;
    text_char_t      c;
    mag   = value;
    neg   = 1'b0;
    n     = 0;
    width = 0;
    if (func > FN_HEX) return;
    if (func == FN_SDEC && value[ValW-1]) begin
      neg = 1'b1;
      mag = -value;
    end
    while (mag != '0 && n < 64) begin
      case (func)
        FN_BIN: begin
          d   = {3'b000, mag[0]};
          mag = mag >> 1;
        end
        FN_OCT: begin
          d   = {1'b0, mag[2:0]};
          mag = mag >> 3;
        end
        FN_HEX: begin
          d   = mag[3:0];
          mag = mag >> 4;
        end
        default: begin
          rem = mag % 64'd10;
          d   = rem[3:0];
          mag = mag / 64'd10;
        end
      endcase
      digs[n] = DigitSet[8 * (15 - int'(d)) +: 8];
      n++;
    end
    // octal and signed decimal never pad
    if (pad) begin
      case (func)
        FN_UDEC: width = PadDecW;
        FN_HEX:  width = PadHexW;
        FN_BIN:  width = PadBinW;
        default: width = 0;
      endcase
    end
    while (n < width) begin
      digs[n] = AsciiZero;
      n++;
    end
    if (n == 0) begin
      digs[0] = AsciiZero;
      n = 1;
    end
    if (neg) begin
      c.character = AsciiMinus;
      c.is_last   = 1'b0;
      expected_text.push_back(c);
    end
    for (int k = n - 1; k >= 0; k--) begin
      c.character = digs[k];
      c.is_last   = (k == 0);
      expected_text.push_back(c);
    end
  endfunction

  always @(posedge clk) begin
    text_char_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        append_radix_text(in_value, in_func, in_zero_pad);
      end
      if (out_valid && out_ready) begin
        if (expected_text.size() == 0) begin
          mismatches++;
          if (mismatches <= MaxReports) begin
            $display("%0t: unexpected character: expected none, actual %h last %b",
                     $time, out_character, out_last);
          end
        end else begin
          want = expected_text.pop_front();
          checked++;
          if (out_character !== want.character) begin
            mismatches++;
            if (mismatches <= MaxReports) begin
              $display("%0t: character mismatch: expected %h, actual %h",
                       $time, want.character, out_character);
            end
          end
          if (out_last !== want.is_last) begin
            mismatches++;
            if (mismatches <= MaxReports) begin
              $display("%0t: last flag mismatch: expected %b, actual %b",
                       $time, want.is_last, out_last);
            end
          end
        end
      end
    end
    fail_count    <= mismatches;
    pending_count <= expected_text.size();
    chars_checked <= checked;
  end

endmodule

/* verif/tb_integer_to_radix_text.sv */
module tb_integer_to_radix_text
  import itrt_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int         RandomItems = 260;
  localparam int         QuietItems  = 40;
  localparam int         HoldCycles  = 400;
  localparam int         DrainCycles = 200;
  localparam int         CycleLimit  = 1500000;
  localparam logic [2:0] FnMax       = 3'd7;

  logic            clk;
  logic            rst_n;
  logic            in_valid;
  logic            in_ready;
  logic [ValW-1:0] in_value;
  logic [2:0]      in_func;
  logic            in_zero_pad;
  logic            out_valid;
  logic            out_ready;
  logic [7:0]      out_character;
  logic            out_last;

  int   fail_count;
  int   pending_count;
  int   chars_checked;
  int   cycle_count = 0;
  int   mode_count [0:7];
  int   padded_count = 0;
  logic quiet = 1'b0;
  logic rx_hold_armed = 1'b0;

  integer_to_radix_text dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_value     (in_value),
    .in_func      (in_func),
    .in_zero_pad  (in_zero_pad),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_character(out_character),
    .out_last     (out_last)
  );

  radix_text_checker checker_i (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_value     (in_value),
    .in_func      (in_func),
    .in_zero_pad  (in_zero_pad),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_character(out_character),
    .out_last     (out_last),
    .fail_count   (fail_count),
    .pending_count(pending_count),
    .chars_checked(chars_checked)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timed out after %0d cycles, %0d characters outstanding",
               cycle_count, pending_count);
      $display("integer_to_radix_text regression: fail");
      $finish;
    end
  end

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    out_ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (rx_hold_armed) begin
        rx_hold_armed = 1'b0;
        out_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end else if (!quiet && $urandom_range(3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(17, 1)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(20, 1)) @(posedge clk);
      end
    end
  end

  task automatic send_request(input logic [ValW-1:0] value, input logic [2:0] func,
                              input logic pad);
    in_valid    <= 1'b1;
    in_value    <= value;
    in_func     <= func;
    in_zero_pad <= pad;
    mode_count[func]++;
    if (pad) padded_count++;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic sender_gap();
    if (!quiet && $urandom_range(3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(17, 1)) @(posedge clk);
    end
  endtask

  function automatic logic [ValW-1:0] random_value();
    logic [ValW-1:0] v;
    logic [ValW-1:0] p;
    case ($urandom_range(5))
      0: v = {$urandom, $urandom};
      1: v = 64'($urandom_range(255));
      2: v = {$urandom, $urandom} >> $urandom_range(63);
      3: v = (64'd1 << $urandom_range(63)) - 64'($urandom_range(1));
      4: v = {$urandom_range(1) ? 32'h8000_0000 : 32'hffff_ffff, 32'($urandom_range(3))}
             ^ 64'($urandom_range(7));
      default: begin
        // decimal digit-count boundaries
        p = 64'd1;
        repeat ($urandom_range(19)) p = p * 64'd10;
        v = p - 64'($urandom_range(2)) + 64'd1;
      end
    endcase
    return v;
  endfunction

  initial begin
    int              valid_sent;
    int              total_sent;
    int              unused_modes;
    logic [2:0]      f;
    foreach (mode_count[i]) mode_count[i] = 0;
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_value    <= '0;
    in_func     <= FN_SDEC;
    in_zero_pad <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero in every mode unpadded, and padded in all modes but signed decimal
    for (int m = FN_SDEC; m <= FN_HEX; m++) send_request('0, 3'(m), 1'b0);
    send_request('0, FN_UDEC, 1'b1);
    send_request('0, FN_BIN, 1'b1);
    send_request('0, FN_OCT, 1'b1);
    send_request('0, FN_HEX, 1'b1);
    // all ones in every mode
    for (int m = FN_SDEC; m <= FN_HEX; m++) send_request('1, 3'(m), 1'b0);
    send_request(64'h8000_0000_0000_0000, FN_SDEC, 1'b0);
    send_request(64'h7fff_ffff_ffff_ffff, FN_SDEC, 1'b0);
    send_request('1, FN_UDEC, 1'b1);
    send_request(64'd12345, FN_UDEC, 1'b1);
    send_request(64'habc, FN_HEX, 1'b1);
    send_request(64'd5, FN_BIN, 1'b1);
    send_request('1, FN_SDEC, 1'b1);
    send_request(64'o777, FN_OCT, 1'b1);
    // unused modes must stay silent
    for (int m = FN_HEX + 1; m <= FnMax; m++) send_request({$urandom, $urandom}, 3'(m), 1'b1);

    // receiver holds off while requests keep coming
    rx_hold_armed = 1'b1;
    while (rx_hold_armed) @(posedge clk);
    for (int i = 0; i < 8; i++) send_request({$urandom, $urandom}, FN_BIN, 1'b1);

    // sender pauses until the block has drained
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
    repeat (DrainCycles) @(posedge clk);

    valid_sent = 0;
    while (valid_sent < RandomItems) begin
      if (valid_sent >= RandomItems - QuietItems) quiet = 1'b1;
      sender_gap();
      if ($urandom_range(9) == 0) begin
        f = 3'($urandom_range(FnMax, FN_HEX + 1));
      end else begin
        f = 3'($urandom_range(FN_HEX, FN_SDEC));
        valid_sent++;
      end
      send_request(random_value(), f, 1'($urandom_range(1)));
    end
    in_valid <= 1'b0;

    do @(posedge clk); while (pending_count != 0);
    repeat (DrainCycles) @(posedge clk);

    total_sent   = 0;
    unused_modes = 0;
    foreach (mode_count[i]) begin
      total_sent += mode_count[i];
      if (i > FN_HEX) unused_modes += mode_count[i];
    end
    $display("covered %0d requests: sdec %0d udec %0d bin %0d oct %0d hex %0d unused %0d",
             total_sent,
             mode_count[FN_SDEC], mode_count[FN_UDEC], mode_count[FN_BIN],
             mode_count[FN_OCT], mode_count[FN_HEX], unused_modes);
    $display("%0d with zero padding, %0d characters checked, long output stall included",
             padded_count, chars_checked);
    if (fail_count == 0 && pending_count == 0) begin
      $display("integer_to_radix_text regression: pass");
    end else begin
      $display("integer_to_radix_text regression: fail");
    end
    $finish;
  end

endmodule
